FILE: rtl/assert_macros.svh
// Assertion macros used by the checker.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk_i, muted while rst_ni is low.
`define COUR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cour check failed");

// Same check, written as a same-cycle implication.
`define COUR_ASSERT_IMP(lbl, ante, cons) \
  `COUR_ASSERT(lbl, (ante) |-> (cons))

// Same check, consequent in the cycle after the antecedent.
`define COUR_ASSERT_NXT(lbl, ante, cons) \
  `COUR_ASSERT(lbl, (ante) |=> (cons))

`endif

FILE: rtl/cour_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the receiver.
// No dependencies; imported by every module of the block.
package cour_pkg;

  localparam int unsigned FrameBytes = 19;
  localparam int unsigned CrcSpan    = 17;
  localparam int unsigned IdxW       = 5;

  localparam logic [31:0] MagicReset = 32'hAABB_CCDD;
  localparam logic [7:0]  MaxData    = 8'd8;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  localparam logic [1:0] StsGood   = 2'd0;
  localparam logic [1:0] StsCrcBad = 2'd1;
  localparam logic [1:0] StsLenBad = 2'd2;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StCrc   = 4'b0100,
    StEmit  = 4'b1000
  } cour_state_e;

  // controller -> datapath
  typedef struct packed {
    logic shift;      // take rx byte into window
    logic drop;       // magic miss: keep 18 newest bytes
    logic crc_start;
    logic crc_step;
    logic emit;       // load result register, empty window
  } cour_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_byte;  // next byte fills the window
    logic magic_ok;
    logic crc_done;   // current step covers the last CRC byte
    logic out_busy;   // result register still occupied
  } cour_sts_t;

  // reflected CRC-16, one byte, eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/cour_ctrl.sv
// Sequencing state machine of the frame receiver.
// Depends on cour_pkg (state enum, command and status structs).
module cour_ctrl import cour_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cour_sts_t sts_i,
  output cour_cmd_t cmd_o
);

  cour_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift = 1'b1;
          if (sts_i.last_byte) state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.magic_ok) begin
          cmd_o.crc_start = 1'b1;
          state_d         = StCrc;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = StIdle;
        end
      end
      StCrc: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_done) state_d = StEmit;
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cour_dp.sv
// Datapath: byte window, magic register, serial CRC unit and result register.
// Depends on cour_pkg (constants, structs, crc16_byte).
module cour_dp import cour_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  cour_cmd_t   cmd_i,
  output cour_sts_t   sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] can_id_o,
  output logic [7:0]  payload_len_o,
  output logic [63:0] payload_o       // payload_0 in [7:0] .. payload_7 in [63:56]
);

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameBytes - 1);
  localparam logic [IdxW-1:0] CrcLast  = IdxW'(CrcSpan - 1);

  // oldest byte at index 0, newest enters at the top
  logic [7:0]      win_q [FrameBytes];
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [31:0]     magic_q;
  logic [15:0]     crc_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [31:0]     can_id_q;
  logic [7:0]      len_q;
  logic [63:0]     payload_q;
  logic [15:0]     rx_crc;
  logic [1:0]      status_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = 0; i < FrameBytes - 1; i++) win_q[i] <= win_q[i+1];
      win_q[FrameBytes-1] <= rx_byte_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.shift) cnt_d = cnt_q + IdxW'(1);
    if (cmd_i.drop)  cnt_d = LastIdx;
    if (cmd_i.emit)  cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      magic_q <= MagicReset;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) magic_q <= cfg_data_i;
    end
  end

  // CRC walks window bytes 0..16, one per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.crc_start) begin
      crc_q <= CrcInit;
      idx_q <= '0;
    end else if (cmd_i.crc_step) begin
      crc_q <= crc16_byte(crc_q, win_q[idx_q]);
      idx_q <= idx_q + IdxW'(1);
    end
  end

  assign rx_crc = {win_q[18], win_q[17]};

  always_comb begin
    if (crc_q != rx_crc)     status_d = StsCrcBad;
    else if (win_q[8] > MaxData) status_d = StsLenBad;
    else                     status_d = StsGood;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= status_d;
      can_id_q   <= {win_q[7], win_q[6], win_q[5], win_q[4]};
      len_q      <= win_q[8];
      payload_q  <= {win_q[16], win_q[15], win_q[14], win_q[13],
                     win_q[12], win_q[11], win_q[10], win_q[9]};
    end
  end

  assign sts_o.last_byte = (cnt_q == LastIdx);
  assign sts_o.magic_ok  = ({win_q[3], win_q[2], win_q[1], win_q[0]} == magic_q);
  assign sts_o.crc_done  = (idx_q == CrcLast);
  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign can_id_o      = can_id_q;
  assign payload_len_o = len_q;
  assign payload_o     = payload_q;

endmodule

FILE: rtl/can_over_uart_frame_receiver.sv
// Top level of the serial frame receiver: controller plus datapath.
// Depends on cour_pkg, cour_ctrl and cour_dp.
//
// Receives one serial byte per request on the slave stream and keeps the
// 19 most recent bytes of the current fill. A frame is: 4-byte magic word,
// 4-byte frame id, length byte, 8 data bytes, 2-byte CRC, all little-endian.
// A byte that does not complete the window is taken and the block stays idle. When a
// byte completes it, the magic word is checked in the next cycle; on a miss the
// oldest byte falls out and input resumes. On a hit
// the CRC-16/MODBUS unit walks bytes 0..16 at one byte per cycle,
// then the result is loaded into the output register once it is free, so a completing byte
// holds the input through the serial CRC walk and until that load. The
// result register lets the next frame's bytes come in while a result waits;
// a second result waits until the first has been taken. tuser carries the
// status: 0 good, 1 CRC mismatch, 2 CRC good but length above eight. All
// fields carry the received bytes unchanged whatever the status. The magic
// word register resets to 0xAABBCCDD; write it only while the block is idle.
module can_over_uart_frame_receiver import cour_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // magic word write channel
  input  logic         cfg_wvalid_i,
  output logic         cfg_wready_o,
  input  logic [31:0]  cfg_wdata_i,     // [31:0] magic_word
  // received bytes
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] rx_byte
  // frame results
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,  // [31:0] can_id, [39:32] payload_len,
                                        // [47:40] payload_0 .. [103:96] payload_7
  output logic [1:0]   m_axis_tuser_o   // [1:0] status
);

  cour_cmd_t   cmd;
  cour_sts_t   sts;
  logic [31:0] can_id;
  logic [7:0]  payload_len;
  logic [63:0] payload;

  // register writes are always taken
  assign cfg_wready_o = 1'b1;

  cour_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cour_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (s_axis_tdata_i),
    .cfg_we_i      (cfg_wvalid_i),
    .cfg_data_i    (cfg_wdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (m_axis_tuser_o),
    .can_id_o      (can_id),
    .payload_len_o (payload_len),
    .payload_o     (payload)
  );

  assign m_axis_tdata_o = {payload, payload_len, can_id};

endmodule

FILE: rtl/cour_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
// Depends on cour_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cour_checker import cour_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [103:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o & ~m_axis_tready_i;

  `COUR_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `COUR_ASSERT_IMP(a_sts_code, m_axis_tvalid_o, m_axis_tuser_o != 2'd3)
  `COUR_ASSERT_IMP(a_len_flag, m_axis_tvalid_o && m_axis_tuser_o == StsLenBad,
                   m_axis_tdata_o[39:32] > MaxData)
  `COUR_ASSERT_IMP(a_emit_gap, $rose(m_axis_tvalid_o), !$past(in_acc))

endmodule

bind can_over_uart_frame_receiver cour_checker u_cour_checker (.*);
